/* design/asru_pkg.sv */
// Shared types, codes and the micro-program for the asphere sag and refraction unit.
// Used by the queue, the sequencer, the arithmetic unit and the top level.
// Depends on nothing.
package asru_pkg;

    // Queue between front and back.
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // Arithmetic operation codes.
    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_DIV  = 3'd3;
    localparam logic [2:0] OP_SQRT = 3'd4;

    // Result status codes.
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_SAG = 2'd1;
    localparam logic [1:0] ST_TIR = 2'd2;

    // Register index codes of the configuration port.
    localparam logic [2:0] CFG_CURV  = 3'd0;
    localparam logic [2:0] CFG_KAPPA = 3'd1;
    localparam logic [2:0] CFG_R4    = 3'd2;
    localparam logic [2:0] CFG_R6    = 3'd3;
    localparam logic [2:0] CFG_VZ    = 3'd4;
    localparam logic [2:0] CFG_N2    = 3'd5;

    // Operand sources: temporaries live in the scratch RAM, the rest are fixed.
    localparam logic [4:0] SRC_T0    = 5'd0;
    localparam logic [4:0] SRC_T1    = 5'd1;
    localparam logic [4:0] SRC_T2    = 5'd2;
    localparam logic [4:0] SRC_T3    = 5'd3;
    localparam logic [4:0] SRC_T4    = 5'd4;
    localparam logic [4:0] SRC_T5    = 5'd5;
    localparam logic [4:0] SRC_T6    = 5'd6;
    localparam logic [4:0] SRC_T7    = 5'd7;
    localparam logic [4:0] SRC_T8    = 5'd8;
    localparam logic [4:0] SRC_T9    = 5'd9;
    localparam logic [4:0] SRC_T10   = 5'd10;
    localparam logic [4:0] SRC_CURV  = 5'd16;
    localparam logic [4:0] SRC_KAPPA = 5'd17;
    localparam logic [4:0] SRC_A     = 5'd18;
    localparam logic [4:0] SRC_B     = 5'd19;
    localparam logic [4:0] SRC_VZ    = 5'd20;
    localparam logic [4:0] SRC_N2    = 5'd21;
    localparam logic [4:0] SRC_R     = 5'd22;
    localparam logic [4:0] SRC_DZ    = 5'd23;
    localparam logic [4:0] SRC_DY    = 5'd24;
    localparam logic [4:0] SRC_N1    = 5'd25;
    localparam logic [4:0] SRC_ONE   = 5'd26;
    localparam logic [4:0] SRC_FOUR  = 5'd27;
    localparam logic [4:0] SRC_SIX   = 5'd28;
    localparam logic [4:0] SRC_ZERO  = 5'd29;

    // Temporaries that also feed the result registers.
    localparam logic [4:0] SRC_SAG = SRC_T7;
    localparam logic [4:0] SRC_OZ  = SRC_T9;
    localparam logic [4:0] SRC_OY  = SRC_T10;

    localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;

    // One ray as queued.
    typedef struct packed {
        logic [63:0] ray_height;
        logic [63:0] dir_z;
        logic [63:0] dir_y;
        logic [62:0] incident_index;
    } t_ray;

    // Surface configuration.
    typedef struct packed {
        logic [63:0] curvature;
        logic [63:0] conic_constant;
        logic [63:0] coef_r4;
        logic [63:0] coef_r6;
        logic [63:0] vertex_z;
        logic [62:0] lens_index;
    } t_cfg;

    // Request to the arithmetic unit.
    typedef struct packed {
        logic [2:0]  op;
        logic [63:0] a;
        logic [63:0] b;
    } t_alu_req;

    // One micro-instruction: a negative result ends the ray with neg_st when it is nonzero.
    typedef struct packed {
        logic [2:0] op;
        logic [4:0] a;
        logic [4:0] b;
        logic [4:0] d;
        logic [1:0] neg_st;
        logic       last;
    } t_uop;

    // Saturate a 65-bit signed sum to 64 bits.
    function automatic logic [63:0] sat65(input logic [64:0] v);
        if (v[64] != v[63]) begin
            return v[64] ? SMIN : SMAX;
        end
        return v[63:0];
    endfunction

    // Magnitude of a signed 64-bit value; the most negative value gives 2^63.
    function automatic logic [63:0] mag64(input logic [63:0] x);
        return x[63] ? (64'd0 - x) : x;
    endfunction

    // Apply a sign to a magnitude with saturation.
    function automatic logic [63:0] pack(input logic neg, input logic ovf,
                                         input logic [63:0] mag);
        if (neg) begin
            if (ovf || (mag > SMIN)) begin
                return SMIN;
            end
            return 64'd0 - mag;
        end
        if (ovf || mag[63]) begin
            return SMAX;
        end
        return mag;
    endfunction

    function automatic t_uop mk(input logic [2:0] op, input logic [4:0] a,
                                input logic [4:0] b, input logic [4:0] d,
                                input logic [1:0] neg_st, input logic last);
        t_uop u;
        u.op = op;
        u.a = a;
        u.b = b;
        u.d = d;
        u.neg_st = neg_st;
        u.last = last;
        return u;
    endfunction

    // Micro-program for one ray: sag, slope, normal, then Snell refraction.
    function automatic t_uop prog(input logic [5:0] pc);
        t_uop u;
        u = mk(OP_ADD, SRC_ZERO, SRC_ZERO, SRC_T0, ST_OK, 1'b1);
        case (pc)
            // Sag root argument 1 - (1+k)(cr)^2.
            6'd0:  u = mk(OP_MUL,  SRC_CURV, SRC_R,     SRC_T0,  ST_OK,  1'b0);
            6'd1:  u = mk(OP_MUL,  SRC_T0,   SRC_T0,    SRC_T1,  ST_OK,  1'b0);
            6'd2:  u = mk(OP_ADD,  SRC_ONE,  SRC_KAPPA, SRC_T2,  ST_OK,  1'b0);
            6'd3:  u = mk(OP_MUL,  SRC_T2,   SRC_T1,    SRC_T1,  ST_OK,  1'b0);
            6'd4:  u = mk(OP_SUB,  SRC_ONE,  SRC_T1,    SRC_T1,  ST_SAG, 1'b0);
            6'd5:  u = mk(OP_SQRT, SRC_T1,   SRC_ZERO,  SRC_T1,  ST_OK,  1'b0);
            // Powers of the ray height.
            6'd6:  u = mk(OP_MUL,  SRC_R,    SRC_R,     SRC_T2,  ST_OK,  1'b0);
            6'd7:  u = mk(OP_MUL,  SRC_T2,   SRC_R,     SRC_T3,  ST_OK,  1'b0);
            6'd8:  u = mk(OP_MUL,  SRC_T2,   SRC_T2,    SRC_T4,  ST_OK,  1'b0);
            6'd9:  u = mk(OP_MUL,  SRC_T4,   SRC_R,     SRC_T5,  ST_OK,  1'b0);
            6'd10: u = mk(OP_MUL,  SRC_T4,   SRC_T2,    SRC_T6,  ST_OK,  1'b0);
            // Sag.
            6'd11: u = mk(OP_MUL,  SRC_CURV, SRC_T2,    SRC_T7,  ST_OK,  1'b0);
            6'd12: u = mk(OP_ADD,  SRC_ONE,  SRC_T1,    SRC_T8,  ST_OK,  1'b0);
            6'd13: u = mk(OP_DIV,  SRC_T7,   SRC_T8,    SRC_T7,  ST_OK,  1'b0);
            6'd14: u = mk(OP_ADD,  SRC_T7,   SRC_VZ,    SRC_T7,  ST_OK,  1'b0);
            6'd15: u = mk(OP_MUL,  SRC_A,    SRC_T4,    SRC_T8,  ST_OK,  1'b0);
            6'd16: u = mk(OP_ADD,  SRC_T7,   SRC_T8,    SRC_T7,  ST_OK,  1'b0);
            6'd17: u = mk(OP_MUL,  SRC_B,    SRC_T6,    SRC_T8,  ST_OK,  1'b0);
            6'd18: u = mk(OP_ADD,  SRC_T7,   SRC_T8,    SRC_SAG, ST_OK,  1'b0);
            // Slope.
            6'd19: u = mk(OP_DIV,  SRC_T0,   SRC_T1,    SRC_T0,  ST_OK,  1'b0);
            6'd20: u = mk(OP_MUL,  SRC_A,    SRC_T3,    SRC_T8,  ST_OK,  1'b0);
            6'd21: u = mk(OP_MUL,  SRC_T8,   SRC_FOUR,  SRC_T8,  ST_OK,  1'b0);
            6'd22: u = mk(OP_ADD,  SRC_T0,   SRC_T8,    SRC_T0,  ST_OK,  1'b0);
            6'd23: u = mk(OP_MUL,  SRC_B,    SRC_T5,    SRC_T8,  ST_OK,  1'b0);
            6'd24: u = mk(OP_MUL,  SRC_T8,   SRC_SIX,   SRC_T8,  ST_OK,  1'b0);
            6'd25: u = mk(OP_ADD,  SRC_T0,   SRC_T8,    SRC_T0,  ST_OK,  1'b0);
            // Normal.
            6'd26: u = mk(OP_MUL,  SRC_T0,   SRC_T0,    SRC_T8,  ST_OK,  1'b0);
            6'd27: u = mk(OP_ADD,  SRC_T8,   SRC_ONE,   SRC_T8,  ST_OK,  1'b0);
            6'd28: u = mk(OP_SQRT, SRC_T8,   SRC_ZERO,  SRC_T8,  ST_OK,  1'b0);
            6'd29: u = mk(OP_DIV,  SRC_ONE,  SRC_T8,    SRC_T2,  ST_OK,  1'b0);
            6'd30: u = mk(OP_SUB,  SRC_ZERO, SRC_T0,    SRC_T3,  ST_OK,  1'b0);
            6'd31: u = mk(OP_DIV,  SRC_T3,   SRC_T8,    SRC_T3,  ST_OK,  1'b0);
            // Incidence angle and refraction angle.
            6'd32: u = mk(OP_MUL,  SRC_T2,   SRC_DZ,    SRC_T4,  ST_OK,  1'b0);
            6'd33: u = mk(OP_MUL,  SRC_T3,   SRC_DY,    SRC_T5,  ST_OK,  1'b0);
            6'd34: u = mk(OP_ADD,  SRC_T4,   SRC_T5,    SRC_T4,  ST_OK,  1'b0);
            6'd35: u = mk(OP_MUL,  SRC_T4,   SRC_T4,    SRC_T5,  ST_OK,  1'b0);
            6'd36: u = mk(OP_SUB,  SRC_ONE,  SRC_T5,    SRC_T5,  ST_OK,  1'b0);
            6'd37: u = mk(OP_SQRT, SRC_T5,   SRC_ZERO,  SRC_T5,  ST_OK,  1'b0);
            6'd38: u = mk(OP_MUL,  SRC_N1,   SRC_T5,    SRC_T5,  ST_OK,  1'b0);
            6'd39: u = mk(OP_DIV,  SRC_T5,   SRC_N2,    SRC_T5,  ST_OK,  1'b0);
            6'd40: u = mk(OP_MUL,  SRC_T5,   SRC_T5,    SRC_T5,  ST_OK,  1'b0);
            6'd41: u = mk(OP_SUB,  SRC_ONE,  SRC_T5,    SRC_T5,  ST_TIR, 1'b0);
            6'd42: u = mk(OP_SQRT, SRC_T5,   SRC_ZERO,  SRC_T5,  ST_OK,  1'b0);
            6'd43: u = mk(OP_MUL,  SRC_N2,   SRC_T5,    SRC_T5,  ST_OK,  1'b0);
            6'd44: u = mk(OP_MUL,  SRC_N1,   SRC_T4,    SRC_T6,  ST_OK,  1'b0);
            6'd45: u = mk(OP_SUB,  SRC_T5,   SRC_T6,    SRC_T5,  ST_OK,  1'b0);
            // Refracted direction.
            6'd46: u = mk(OP_MUL,  SRC_N1,   SRC_DZ,    SRC_T6,  ST_OK,  1'b0);
            6'd47: u = mk(OP_MUL,  SRC_T5,   SRC_T2,    SRC_T0,  ST_OK,  1'b0);
            6'd48: u = mk(OP_ADD,  SRC_T6,   SRC_T0,    SRC_T6,  ST_OK,  1'b0);
            6'd49: u = mk(OP_DIV,  SRC_T6,   SRC_N2,    SRC_OZ,  ST_OK,  1'b0);
            6'd50: u = mk(OP_MUL,  SRC_N1,   SRC_DY,    SRC_T6,  ST_OK,  1'b0);
            6'd51: u = mk(OP_MUL,  SRC_T5,   SRC_T3,    SRC_T0,  ST_OK,  1'b0);
            6'd52: u = mk(OP_ADD,  SRC_T6,   SRC_T0,    SRC_T6,  ST_OK,  1'b0);
            6'd53: u = mk(OP_DIV,  SRC_T6,   SRC_N2,    SRC_OY,  ST_OK,  1'b1);
            default: u = mk(OP_ADD, SRC_ZERO, SRC_ZERO, SRC_T0, ST_OK, 1'b1);
        endcase
        return u;
    endfunction

endpackage

/* design/asru_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module asru_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/asru_front.sv */
// Front end: takes rays in and holds them in a short queue for the sequencer.
// Depends on asru_pkg.
module asru_front import asru_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_ray i_item,
    input  logic i_pop,
    output t_ray o_item,
    output logic o_empty,
    output logic o_full
);

    t_ray           r_q [QDEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QAW:0]   r_cnt;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr] <= i_item;
        end
    end

    assign o_item  = r_q[r_rd];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));

endmodule

/* design/asru_alu.sv */
// Shared multi-cycle arithmetic unit: saturated add and subtract, a multiplier built
// from 32x32 partial products, a bit-serial divider and a bit-serial square root.
// Depends on asru_pkg.
module asru_alu import asru_pkg::*; #(
    parameter int FRAC_BITS = 40
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_alu_req    i_req,
    output logic        o_done,
    output logic [63:0] o_res
);

    localparam logic [2:0] A_IDLE = 3'd0;
    localparam logic [2:0] A_MUL  = 3'd1;
    localparam logic [2:0] A_MRND = 3'd2;
    localparam logic [2:0] A_DIV  = 3'd3;
    localparam logic [2:0] A_DRND = 3'd4;
    localparam logic [2:0] A_SQRT = 3'd5;

    localparam logic [127:0] HALF = 128'd1 << (FRAC_BITS - 1);

    logic [2:0]   r_state;
    logic [6:0]   r_cnt;
    logic [63:0]  r_ma;
    logic [63:0]  r_mb;
    logic         r_neg;
    logic [127:0] r_num;
    logic [127:0] r_acc;
    logic [63:0]  r_pp;
    logic [65:0]  r_rem;
    logic         r_done;
    logic [63:0]  r_res;

    logic [64:0]  sum;
    logic [64:0]  diff;
    logic [31:0]  pp_a;
    logic [31:0]  pp_b;
    logic [1:0]   prev;
    logic [127:0] acc_add;
    logic [127:0] mround;
    logic [127:0] mshift;
    logic [64:0]  drem2;
    logic         dge;
    logic [64:0]  drem_new;
    logic         rup;
    logic [127:0] qround;
    logic [67:0]  srem2;
    logic [67:0]  trial;
    logic         sge;
    logic [67:0]  srem_new;

    // Operand math for every operation.
    always_comb begin
        sum  = {i_req.a[63], i_req.a} + {i_req.b[63], i_req.b};
        diff = {i_req.a[63], i_req.a} - {i_req.b[63], i_req.b};

        // Partial product order: low-low, low-high, high-low, high-high.
        pp_a = r_cnt[1] ? r_ma[63:32] : r_ma[31:0];
        pp_b = r_cnt[0] ? r_mb[63:32] : r_mb[31:0];
        prev = 2'(r_cnt - 7'd1);
        case (prev)
            2'd0:    acc_add = 128'(r_pp);
            2'd3:    acc_add = 128'(r_pp) << 64;
            default: acc_add = 128'(r_pp) << 32;
        endcase
        mround = r_acc + HALF;
        mshift = mround >> FRAC_BITS;

        // Restoring division step.
        drem2    = {r_rem[63:0], r_num[127]};
        dge      = drem2 >= {1'b0, r_mb};
        drem_new = dge ? (drem2 - {1'b0, r_mb}) : drem2;
        rup      = r_rem[63:0] >= (r_mb - r_rem[63:0]);
        qround   = r_acc + 128'(rup);

        // Square root step, two radicand bits at a time.
        srem2    = {r_rem, r_num[127:126]};
        trial    = {2'b00, r_acc[63:0], 2'b01};
        sge      = srem2 >= trial;
        srem_new = sge ? (srem2 - trial) : srem2;
    end

    // Sequencing of the multi-cycle operations.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                A_IDLE: begin
                    if (i_start) begin
                        r_neg <= i_req.a[63] ^ i_req.b[63];
                        r_ma  <= mag64(i_req.a);
                        r_mb  <= mag64(i_req.b);
                        r_cnt <= '0;
                        r_acc <= '0;
                        r_rem <= '0;
                        case (i_req.op)
                            OP_ADD: begin
                                r_res  <= sat65(sum);
                                r_done <= 1'b1;
                            end
                            OP_SUB: begin
                                r_res  <= sat65(diff);
                                r_done <= 1'b1;
                            end
                            OP_MUL: begin
                                r_state <= A_MUL;
                            end
                            OP_DIV: begin
                                if (i_req.b == '0) begin
                                    // x/0 saturates by the sign of x, and 0/0 is zero.
                                    if (i_req.a == '0) begin
                                        r_res <= '0;
                                    end else begin
                                        r_res <= i_req.a[63] ? SMIN : SMAX;
                                    end
                                    r_done <= 1'b1;
                                end else begin
                                    r_num   <= 128'(mag64(i_req.a)) << FRAC_BITS;
                                    r_state <= A_DIV;
                                end
                            end
                            OP_SQRT: begin
                                if (i_req.a[63] || (i_req.a == '0)) begin
                                    r_res  <= '0;
                                    r_done <= 1'b1;
                                end else begin
                                    r_num   <= 128'(i_req.a) << FRAC_BITS;
                                    r_state <= A_SQRT;
                                end
                            end
                            default: begin
                                r_res  <= '0;
                                r_done <= 1'b1;
                            end
                        endcase
                    end
                end
                A_MUL: begin
                    if (r_cnt != 7'd4) begin
                        r_pp <= 64'(pp_a) * 64'(pp_b);
                    end
                    if (r_cnt != 7'd0) begin
                        r_acc <= r_acc + acc_add;
                    end
                    if (r_cnt == 7'd4) begin
                        r_state <= A_MRND;
                    end
                    r_cnt <= r_cnt + 7'd1;
                end
                A_MRND: begin
                    r_res   <= pack(r_neg, |mshift[127:64], mshift[63:0]);
                    r_done  <= 1'b1;
                    r_state <= A_IDLE;
                end
                A_DIV: begin
                    r_rem <= {1'b0, drem_new};
                    r_acc <= {r_acc[126:0], dge};
                    r_num <= r_num << 1;
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd127) begin
                        r_state <= A_DRND;
                    end
                end
                A_DRND: begin
                    r_res   <= pack(r_neg, |qround[127:64], qround[63:0]);
                    r_done  <= 1'b1;
                    r_state <= A_IDLE;
                end
                A_SQRT: begin
                    r_rem        <= srem_new[65:0];
                    r_acc[63:0]  <= {r_acc[62:0], sge};
                    r_num        <= r_num << 2;
                    r_cnt        <= r_cnt + 7'd1;
                    if (r_cnt == 7'd63) begin
                        r_res   <= {r_acc[62:0], sge};
                        r_done  <= 1'b1;
                        r_state <= A_IDLE;
                    end
                end
                default: begin
                    r_state <= A_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

/* design/asru_back.sv */
// Back end: micro-programmed sequencer that runs one ray at a time through the
// shared arithmetic unit, with temporaries in a scratch RAM.
// Depends on asru_pkg, asru_ram and asru_alu.
module asru_back import asru_pkg::*; #(
    parameter int FRAC_BITS = 40
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_ray        i_item,
    output logic        o_pop,
    input  t_cfg        i_cfg,
    output logic        o_valid,
    output logic [63:0] o_sag_z,
    output logic [63:0] o_out_dir_z,
    output logic [63:0] o_out_dir_y,
    output logic [1:0]  o_status
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_OP   = 2'd2;
    localparam logic [1:0] S_WAIT = 2'd3;

    localparam logic [63:0] ONE  = 64'd1 << FRAC_BITS;
    localparam logic [63:0] FOUR = 64'd4 << FRAC_BITS;
    localparam logic [63:0] SIX  = 64'd6 << FRAC_BITS;

    logic [1:0]  r_state;
    logic [5:0]  r_pc;
    t_ray        r_item;
    logic [63:0] r_sag;
    logic [63:0] r_oz;
    logic [63:0] r_oy;
    logic [1:0]  r_status;
    logic        r_valid;

    t_uop        uop;
    logic [63:0] rdata_a;
    logic [63:0] rdata_b;
    t_alu_req    req;
    logic        alu_start;
    logic        alu_done;
    logic [63:0] alu_res;
    logic        wr_en;
    logic        neg_stop;

    // Operand source selection.
    function automatic logic [63:0] pick(input logic [4:0] src, input logic [63:0] mem);
        case (src)
            SRC_CURV:  pick = i_cfg.curvature;
            SRC_KAPPA: pick = i_cfg.conic_constant;
            SRC_A:     pick = i_cfg.coef_r4;
            SRC_B:     pick = i_cfg.coef_r6;
            SRC_VZ:    pick = i_cfg.vertex_z;
            SRC_N2:    pick = {1'b0, i_cfg.lens_index};
            SRC_R:     pick = r_item.ray_height;
            SRC_DZ:    pick = r_item.dir_z;
            SRC_DY:    pick = r_item.dir_y;
            SRC_N1:    pick = {1'b0, r_item.incident_index};
            SRC_ONE:   pick = ONE;
            SRC_FOUR:  pick = FOUR;
            SRC_SIX:   pick = SIX;
            SRC_ZERO:  pick = '0;
            default:   pick = mem;
        endcase
    endfunction

    always_comb begin
        uop       = prog(r_pc);
        req.op    = uop.op;
        req.a     = pick(uop.a, rdata_a);
        req.b     = pick(uop.b, rdata_b);
        alu_start = (r_state == S_OP);
        wr_en     = (r_state == S_WAIT) && alu_done;
        neg_stop  = (uop.neg_st != ST_OK) && alu_res[63];
        o_pop     = (r_state == S_IDLE) && !i_empty;
    end

    // Two copies of the scratch RAM give two operand reads per instruction.
    asru_ram #(.WIDTH(64), .DEPTH(16)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (uop.d[3:0]),
        .i_wdata (alu_res),
        .i_raddr (uop.a[3:0]),
        .o_rdata (rdata_a)
    );

    asru_ram #(.WIDTH(64), .DEPTH(16)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (uop.d[3:0]),
        .i_wdata (alu_res),
        .i_raddr (uop.b[3:0]),
        .o_rdata (rdata_b)
    );

    asru_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (alu_start),
        .i_req   (req),
        .o_done  (alu_done),
        .o_res   (alu_res)
    );

    // Instruction sequencing and result capture.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_pc    <= '0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_item  <= i_item;
                        r_pc    <= '0;
                        r_sag   <= '0;
                        r_oz    <= '0;
                        r_oy    <= '0;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_OP;
                end
                S_OP: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (alu_done) begin
                        if (uop.d == SRC_SAG) begin
                            r_sag <= alu_res;
                        end
                        if (uop.d == SRC_OZ) begin
                            r_oz <= alu_res;
                        end
                        if (uop.d == SRC_OY) begin
                            r_oy <= alu_res;
                        end
                        if (neg_stop) begin
                            r_status <= uop.neg_st;
                            r_valid  <= 1'b1;
                            r_state  <= S_IDLE;
                        end else if (uop.last) begin
                            r_status <= ST_OK;
                            r_valid  <= 1'b1;
                            r_state  <= S_IDLE;
                        end else begin
                            r_pc    <= r_pc + 6'd1;
                            r_state <= S_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid     = r_valid;
    assign o_sag_z     = r_sag;
    assign o_out_dir_z = r_oz;
    assign o_out_dir_y = r_oy;
    assign o_status    = r_status;

endmodule

/* design/asphere_sag_and_refraction_unit.sv */
// A ray that runs to the end spends most of its time in the bit-serial divider (seven
// divisions) and in the bit-serial square root (four square roots).
// One ray is computed at a time; four more rays wait in the input queue.
// The result strobe o_valid is high for one cycle and cannot be stalled.
// Reset is synchronous and active low; it empties the queue and loads the register defaults.
// Depends on asru_pkg, asru_front and asru_back.
module asphere_sag_and_refraction_unit import asru_pkg::*; #(
    parameter int FRAC_BITS = 40
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] i_ray_height,
    input  logic [63:0] i_dir_z,
    input  logic [63:0] i_dir_y,
    input  logic [62:0] i_incident_index,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output logic        o_valid,
    output logic [63:0] o_sag_z,
    output logic [63:0] o_out_dir_z,
    output logic [63:0] o_out_dir_y,
    output logic [1:0]  o_status
);

    localparam logic [62:0] N2_RESET = 63'd3 << (FRAC_BITS - 1);

    t_cfg r_cfg;
    t_ray in_item;
    t_ray q_item;
    logic q_empty;
    logic q_full;
    logic push;
    logic pop;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.curvature      <= '0;
            r_cfg.conic_constant <= '0;
            r_cfg.coef_r4        <= '0;
            r_cfg.coef_r6        <= '0;
            r_cfg.vertex_z       <= '0;
            r_cfg.lens_index     <= N2_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CURV:  r_cfg.curvature      <= i_cfg_data;
                CFG_KAPPA: r_cfg.conic_constant <= i_cfg_data;
                CFG_R4:    r_cfg.coef_r4        <= i_cfg_data;
                CFG_R6:    r_cfg.coef_r6        <= i_cfg_data;
                CFG_VZ:    r_cfg.vertex_z       <= i_cfg_data;
                CFG_N2:    r_cfg.lens_index     <= i_cfg_data[62:0];
                default:   ;
            endcase
        end
    end

    // Input transaction handshake.
    always_comb begin
        busy                   = q_full;
        push                   = start && !q_full;
        in_item.ray_height     = i_ray_height;
        in_item.dir_z          = i_dir_z;
        in_item.dir_y          = i_dir_y;
        in_item.incident_index = i_incident_index;
    end

    asru_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (in_item),
        .i_pop   (pop),
        .o_item  (q_item),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    asru_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_item      (q_item),
        .o_pop       (pop),
        .i_cfg       (r_cfg),
        .o_valid     (o_valid),
        .o_sag_z     (o_sag_z),
        .o_out_dir_z (o_out_dir_z),
        .o_out_dir_y (o_out_dir_y),
        .o_status    (o_status)
    );

    // A result strobe is always followed by o_valid low.
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for two cycles");

    // A negative sag root gives all-zero outputs.
    a_sag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_SAG)) |->
        ((o_sag_z == '0) && (o_out_dir_z == '0) && (o_out_dir_y == '0)))
        else $error("sag root error with nonzero outputs");

    // Total internal reflection gives a zero direction.
    a_tir_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_TIR)) |->
        ((o_out_dir_z == '0) && (o_out_dir_y == '0)))
        else $error("total internal reflection with nonzero direction");

    // A queue that is full never takes another ray.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !push)
        else $error("ray pushed into a full queue");

endmodule
